// File: rtl/core/nnbt_pkg.sv
// Shared types and constants for the nearest-neighbor blob tracker.
// Used by nnbt_slot and nearest_neighbor_blob_tracker_unit; no dependencies.
`default_nettype none

package nnbt_pkg;

	localparam int NumSlots  = 16;
	localparam int SlotBits  = 4;
	localparam int LiveBits  = 5;
	localparam int CoordBits = 14;
	localparam int FracExtra = 8;
	localparam int SmBits    = CoordBits + FracExtra;
	localparam int IdBits    = 16;
	localparam int AgeBits   = 16;
	localparam int RadBits   = 10;
	localparam int GainBits  = 16;
	localparam int SqBits    = 2 * CoordBits;
	localparam int DistBits  = SqBits + 1;
	localparam int ProdBits  = 40;

	localparam logic [RadBits-1:0]  RadiusReset = 10'd100;
	localparam logic [GainBits-1:0] GainReset   = 16'd655;
	localparam logic [AgeBits-1:0]  AgeMax      = 16'hFFFF;

	// result kinds
	typedef enum logic [1:0] {
		KIND_MATCH  = 2'd0,
		KIND_NEW    = 2'd1,
		KIND_DROP   = 2'd2,
		KIND_CLOSED = 2'd3
	} kind_t;

	// input commands
	localparam logic CmdBlob = 1'b0;
	localparam logic CmdEof  = 1'b1;

	// configuration register indexes
	localparam logic RegRadius = 1'b0;
	localparam logic RegGain   = 1'b1;

	// one track slot
	typedef struct packed {
		logic                 valid;
		logic                 found;
		logic [CoordBits-1:0] pos_x;
		logic [CoordBits-1:0] pos_y;
		logic [SmBits-1:0]    sm_x;
		logic [SmBits-1:0]    sm_y;
		logic [IdBits-1:0]    ident;
		logic [AgeBits-1:0]   age;
	} track_t;

	// per-slot control: move from neighbor, or load update data
	typedef struct packed {
		logic mv;
		logic ld;
	} slot_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/nnbt_slot.sv
// One track slot of the tracker's slot chain.
// Depends on nnbt_pkg for the track record and slot control types.
`default_nettype none

module nnbt_slot (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire nnbt_pkg::slot_ctl_t ctl,
	input  wire nnbt_pkg::track_t   nb_in,
	input  wire nnbt_pkg::track_t   ld_in,
	output nnbt_pkg::track_t        q
);

	// slot record: load update data or take the neighbor's record; reset empties it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (ctl.ld) begin
			q <= ld_in;
		end else if (ctl.mv) begin
			q <= nb_in;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/nearest_neighbor_blob_tracker_unit.sv
// Top level of the nearest-neighbor blob tracker: control, search and smoothing.
// Depends on nnbt_pkg and nnbt_slot.
`default_nettype none

// Usage:
// Input transactions carry cmd, blob_x, blob_y (Q10.4 pixels) on in_valid/in_stall.
// cmd blob matches a centroid to the nearest unfound track in range; cmd end-of-frame
// drops unfound tracks. Each input gives exactly one output transaction on
// out_valid/out_stall with kind, track_id, smooth_x/y, frames_active, live_count.
// Tracks live in a chain of 16 slots. A blob rotates the chain once past the
// distance unit, then steps through compare, multiply and update; the update
// step writes the result into the output register. End of frame rotates once
// (pruning at the wrap and clearing found flags), then packs the chain and
// ends in the update step. One item is in flight at a time; in_stall is high
// while it is worked on.
// The result sits in an output register; the next item is accepted while it
// waits. If out_stall holds, the next result waits in its update step.
// Reset empties the table, clears the id counter and loads radius 100 and
// gain 655. cfg_we writes register cfg_idx (0 radius, 1 gain).
module nearest_neighbor_blob_tracker_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        cmd,
	input  wire logic [13:0] blob_x,
	input  wire logic [13:0] blob_y,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [15:0]      track_id,
	output logic [13:0]      smooth_x,
	output logic [13:0]      smooth_y,
	output logic [15:0]      frames_active,
	output logic [4:0]       live_count
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_CMP  = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_UPD  = 6'b010000,
		ST_PACK = 6'b100000
	} state_t;

	state_t state_q;
	logic [nnbt_pkg::SlotBits-1:0]  cnt_q;
	logic                           cmd_q;
	logic [nnbt_pkg::CoordBits-1:0] bx_q, by_q;
	logic [nnbt_pkg::RadBits-1:0]   radius_q;
	logic [nnbt_pkg::GainBits-1:0]  gain_q;
	logic [nnbt_pkg::DistBits-1:0]  best_q;
	logic                           hit_q;
	logic [nnbt_pkg::SlotBits-1:0]  hit_idx_q;
	nnbt_pkg::track_t               hit_data_q;
	logic [nnbt_pkg::LiveBits-1:0]  kept_q, live_q;
	logic [nnbt_pkg::IdBits-1:0]    next_id_q;
	logic                           out_valid_q;

	nnbt_pkg::track_t    slot_q   [nnbt_pkg::NumSlots];
	nnbt_pkg::track_t    nb       [nnbt_pkg::NumSlots];
	nnbt_pkg::slot_ctl_t ctl      [nnbt_pkg::NumSlots];
	logic                shift_c  [nnbt_pkg::NumSlots];

	logic in_accept, upd_fire, full, upd_we;
	nnbt_pkg::track_t head, wrap, upd_data;
	logic [nnbt_pkg::SlotBits-1:0] ld_idx;
	nnbt_pkg::kind_t upd_kind;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign upd_fire  = (state_q == ST_UPD) && (!out_valid_q || !out_stall);
	assign full      = (live_q == nnbt_pkg::LiveBits'(nnbt_pkg::NumSlots));
	assign head      = slot_q[0];
	assign out_valid = out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= nnbt_pkg::RadiusReset;
			gain_q   <= nnbt_pkg::GainReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				nnbt_pkg::RegRadius: radius_q <= cfg_data[nnbt_pkg::RadBits-1:0];
				nnbt_pkg::RegGain:   gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == nnbt_pkg::SlotBits'(nnbt_pkg::NumSlots - 1))
						state_q <= (cmd_q == nnbt_pkg::CmdEof) ? ST_PACK : ST_CMP;
				end
				ST_CMP:  state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_UPD;
				ST_UPD: begin
					if (upd_fire) state_q <= ST_IDLE;
				end
				ST_PACK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == nnbt_pkg::SlotBits'(nnbt_pkg::NumSlots - 1))
						state_q <= ST_UPD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// chain neighbor at the top: rotation wrap (pruned at end of frame) or empty when packing
	always_comb begin
		wrap = head;
		if (state_q == ST_PACK) begin
			wrap.valid = 1'b0;
			wrap.found = 1'b0;
		end else if (cmd_q == nnbt_pkg::CmdEof) begin
			wrap.valid = head.valid & head.found;
			wrap.found = 1'b0;
		end
	end

	// slot chain
	for (genvar i = 0; i < nnbt_pkg::NumSlots; i++) begin : g_slot
		if (i == 0) begin : g_first
			assign shift_c[i] = !slot_q[i].valid;
		end else begin : g_rest
			assign shift_c[i] = !slot_q[i].valid | shift_c[i-1];
		end
		if (i == nnbt_pkg::NumSlots - 1) begin : g_top
			assign nb[i] = wrap;
		end else begin : g_mid
			assign nb[i] = slot_q[i+1];
		end
		assign ctl[i] = '{
			mv: (state_q == ST_SCAN) || ((state_q == ST_PACK) && shift_c[i]),
			ld: upd_fire && upd_we && (ld_idx == nnbt_pkg::SlotBits'(i))
		};

		nnbt_slot u_slot (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[i]),
			.nb_in  (nb[i]),
			.ld_in  (upd_data),
			.q      (slot_q[i])
		);
	end

	// distance stage: squares of the head slot's offsets
	logic [nnbt_pkg::CoordBits-1:0] dx, dy;
	logic [nnbt_pkg::SqBits-1:0]    sqx, sqy, sqx_s1, sqy_s1;
	logic                           v_s1, cand_s1;
	logic [nnbt_pkg::SlotBits-1:0]  idx_s1;
	nnbt_pkg::track_t               data_s1;
	logic [nnbt_pkg::DistBits-1:0]  dist_sum;
	logic [nnbt_pkg::CoordBits-1:0] rad16;

	assign dx       = (head.pos_x > bx_q) ? head.pos_x - bx_q : bx_q - head.pos_x;
	assign dy       = (head.pos_y > by_q) ? head.pos_y - by_q : by_q - head.pos_y;
	assign sqx      = nnbt_pkg::SqBits'(dx) * nnbt_pkg::SqBits'(dx);
	assign sqy      = nnbt_pkg::SqBits'(dy) * nnbt_pkg::SqBits'(dy);
	assign dist_sum = nnbt_pkg::DistBits'(sqx_s1) + nnbt_pkg::DistBits'(sqy_s1);
	assign rad16    = {radius_q, 4'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= (state_q == ST_SCAN);
	end

	always_ff @(posedge clk) begin
		sqx_s1  <= sqx;
		sqy_s1  <= sqy;
		cand_s1 <= head.valid & ~head.found;
		idx_s1  <= cnt_q;
		data_s1 <= head;
	end

	// item capture, best-match search and kept count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			kept_q <= '0;
		end else if (in_accept) begin
			hit_q  <= 1'b0;
			kept_q <= '0;
		end else begin
			if (v_s1 && cand_s1 && (dist_sum < best_q)) hit_q <= 1'b1;
			if ((state_q == ST_SCAN) && head.valid && head.found)
				kept_q <= kept_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q  <= cmd;
			bx_q   <= blob_x;
			by_q   <= blob_y;
			best_q <= nnbt_pkg::DistBits'(nnbt_pkg::SqBits'(rad16) * nnbt_pkg::SqBits'(rad16));
		end else if (v_s1 && cand_s1 && (dist_sum < best_q)) begin
			best_q     <= dist_sum;
			hit_idx_q  <= idx_s1;
			hit_data_q <= data_s1;
		end
	end

	// smoothing multiply
	logic signed [nnbt_pkg::SmBits:0]     dfx, dfy;
	logic signed [nnbt_pkg::ProdBits-1:0] gain_s, prod_x_s2, prod_y_s2, rnd_x, rnd_y, dlt_x, dlt_y;

	assign dfx    = $signed({1'b0, bx_q, 8'b0}) - $signed({1'b0, hit_data_q.sm_x});
	assign dfy    = $signed({1'b0, by_q, 8'b0}) - $signed({1'b0, hit_data_q.sm_y});
	assign gain_s = nnbt_pkg::ProdBits'($signed({1'b0, gain_q}));

	always_ff @(posedge clk) begin
		prod_x_s2 <= nnbt_pkg::ProdBits'(dfx) * gain_s;
		prod_y_s2 <= nnbt_pkg::ProdBits'(dfy) * gain_s;
	end

	// round half up to the nearest Q10.12 step
	assign rnd_x = prod_x_s2 + 40'sd32768;
	assign rnd_y = prod_y_s2 + 40'sd32768;
	assign dlt_x = rnd_x >>> 16;
	assign dlt_y = rnd_y >>> 16;

	// update record for the matched or new slot
	always_comb begin
		upd_data       = hit_data_q;
		upd_data.valid = 1'b1;
		upd_data.found = 1'b1;
		upd_data.pos_x = bx_q;
		upd_data.pos_y = by_q;
		upd_we         = 1'b0;
		ld_idx         = hit_idx_q;
		if (cmd_q == nnbt_pkg::CmdEof) begin
			upd_kind = nnbt_pkg::KIND_CLOSED;
		end else if (hit_q) begin
			upd_kind      = nnbt_pkg::KIND_MATCH;
			upd_we        = 1'b1;
			upd_data.sm_x = hit_data_q.sm_x + dlt_x[nnbt_pkg::SmBits-1:0];
			upd_data.sm_y = hit_data_q.sm_y + dlt_y[nnbt_pkg::SmBits-1:0];
			upd_data.age  = (hit_data_q.age == nnbt_pkg::AgeMax) ?
				hit_data_q.age : hit_data_q.age + 1'b1;
		end else if (!full) begin
			upd_kind       = nnbt_pkg::KIND_NEW;
			upd_we         = 1'b1;
			ld_idx         = live_q[nnbt_pkg::SlotBits-1:0];
			upd_data.sm_x  = {bx_q, 8'b0};
			upd_data.sm_y  = {by_q, 8'b0};
			upd_data.ident = next_id_q;
			upd_data.age   = '0;
		end else begin
			upd_kind = nnbt_pkg::KIND_DROP;
		end
	end

	// live count and id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			next_id_q <= '0;
		end else if (upd_fire) begin
			if (upd_kind == nnbt_pkg::KIND_CLOSED) begin
				live_q <= kept_q;
			end else if (upd_kind == nnbt_pkg::KIND_NEW) begin
				live_q    <= live_q + 1'b1;
				next_id_q <= next_id_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       out_valid_q <= 1'b0;
		else if (upd_fire) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			kind <= upd_kind;
			if (upd_we) begin
				track_id      <= upd_data.ident;
				smooth_x      <= upd_data.sm_x[nnbt_pkg::SmBits-1:nnbt_pkg::FracExtra];
				smooth_y      <= upd_data.sm_y[nnbt_pkg::SmBits-1:nnbt_pkg::FracExtra];
				frames_active <= upd_data.age;
			end else begin
				track_id      <= '0;
				smooth_x      <= '0;
				smooth_y      <= '0;
				frames_active <= '0;
			end
			if (upd_kind == nnbt_pkg::KIND_CLOSED) live_count <= kept_q;
			else if (upd_kind == nnbt_pkg::KIND_NEW) live_count <= live_q + 1'b1;
			else live_count <= live_q;
		end
	end

endmodule

`default_nettype wire
